/* sv/fjbs_pkg.sv */
// Shared constants, codes and control types of the flash journal byte store.
// Depends on nothing; every other file of the block imports it.
`default_nettype none
package fjbs_pkg;

	localparam int PAGE_DEPTH     = 256;
	localparam int WRITABLE_SLOTS = 250;
	localparam int SCANNED_SLOTS  = 256;

	localparam int REC_W  = 32;
	localparam int BYTE_W = 8;
	localparam int IDX_W  = 2;
	localparam int ADDR_W = $clog2(PAGE_DEPTH);
	localparam int CNT_W  = ADDR_W + 1;

	// scan and append windows, clipped at the page end
	localparam int SCAN_LIMIT  = (SCANNED_SLOTS > PAGE_DEPTH) ? PAGE_DEPTH : SCANNED_SLOTS;
	localparam int WRITE_LIMIT = (WRITABLE_SLOTS > PAGE_DEPTH) ? PAGE_DEPTH : WRITABLE_SLOTS;
	localparam int SCAN_END    = (SCAN_LIMIT > WRITE_LIMIT) ? SCAN_LIMIT : WRITE_LIMIT;

	localparam logic [REC_W-1:0] ERASED_WORD = '1;

	localparam logic ACT_READ = 1'b0;
	localparam logic ACT_SAVE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_APPLY
	} fjbs_state_t;

	typedef struct packed {
		logic start;   // latch request, restart scan
		logic scan;    // scan step
		logic commit;  // program record and load response
	} fjbs_cmd_t;

	typedef struct packed {
		logic hit;        // erased slot seen in check stage
		logic exhausted;  // last scanned slot checked, not erased
	} fjbs_sts_t;

endpackage
`default_nettype wire

/* sv/fjbs_req_if.sv */
// Request channel: valid/ready handshake with the request payload.
// Depends on fjbs_pkg for field widths.
`default_nettype none
interface fjbs_req_if;
	import fjbs_pkg::*;

	logic              valid;
	logic              ready;
	logic              action;
	logic [IDX_W-1:0]  byte_index;
	logic [BYTE_W-1:0] write_value;

	modport source (output valid, action, byte_index, write_value, input ready);
	modport sink   (input valid, action, byte_index, write_value, output ready);

endinterface
`default_nettype wire

/* sv/fjbs_rsp_if.sv */
// Response channel: valid/ready handshake with the response payload.
// Depends on fjbs_pkg for field widths.
`default_nettype none
interface fjbs_rsp_if;
	import fjbs_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] read_byte;
	logic              record_found;
	logic              slot_written;
	logic              page_erased;

	modport source (output valid, read_byte, record_found, slot_written, page_erased,
		input ready);
	modport sink   (input valid, read_byte, record_found, slot_written, page_erased,
		output ready);

endinterface
`default_nettype wire

/* sv/fjbs_ctrl.sv */
// Controller FSM: sequences accept, slot scan and commit; owns response valid.
// Depends on fjbs_pkg.
`default_nettype none
module fjbs_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	output logic                    rsp_valid,
	input  wire logic               rsp_ready,
	input  wire fjbs_pkg::fjbs_sts_t sts,
	output fjbs_pkg::fjbs_cmd_t     cmd
);
	import fjbs_pkg::*;

	fjbs_state_t state_q, state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.hit || sts.exhausted) state_d = ST_APPLY;
			end
			ST_APPLY: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		req_ready  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.start = req_valid;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
			end
			ST_APPLY: begin
				cmd.commit = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (rsp_ready) out_valid_q <= 1'b0;
		end
	end

	assign rsp_valid = out_valid_q;

endmodule
`default_nettype wire

/* sv/fjbs_dp.sv */
// Datapath: page memory with per-slot valid bits, scan pipeline, record
// update and response register. Depends on fjbs_pkg.
`default_nettype none
module fjbs_dp (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire fjbs_pkg::fjbs_cmd_t       cmd,
	output fjbs_pkg::fjbs_sts_t            sts,
	input  wire logic                      in_action,
	input  wire logic [fjbs_pkg::IDX_W-1:0]  in_byte_index,
	input  wire logic [fjbs_pkg::BYTE_W-1:0] in_write_value,
	output logic [fjbs_pkg::BYTE_W-1:0]    out_read_byte,
	output logic                           out_record_found,
	output logic                           out_slot_written,
	output logic                           out_page_erased
);
	import fjbs_pkg::*;

	localparam logic [ADDR_W-1:0] SCAN_LAST = ADDR_W'(SCAN_END - 1);

	logic [REC_W-1:0]      mem [PAGE_DEPTH];
	logic [PAGE_DEPTH-1:0] slot_vld_q;   // cleared slot reads as erased

	logic              action_q;
	logic [IDX_W-1:0]  byte_index_q;
	logic [BYTE_W-1:0] write_value_q;

	logic [CNT_W-1:0]  rd_addr_q;
	logic              chk_s1;
	logic [REC_W-1:0]  data_s1;
	logic              vld_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic              erased_s1;

	logic              hit_q;
	logic [ADDR_W-1:0] free_q;
	logic [REC_W-1:0]  rec_q;

	logic              found;
	logic              can_append;
	logic [BYTE_W-1:0] old_byte;
	logic [REC_W-1:0]  base_rec;
	logic [REC_W-1:0]  new_rec;
	logic              do_write;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;

	// scan pipeline: issue read, check in the next cycle
	assign erased_s1     = !vld_s1 || (data_s1 == ERASED_WORD);
	assign sts.hit       = chk_s1 && erased_s1;
	assign sts.exhausted = chk_s1 && !erased_s1 && (idx_s1 == SCAN_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_addr_q <= '0;
			chk_s1    <= 1'b0;
			hit_q     <= 1'b0;
		end else begin
			if (cmd.start) begin
				rd_addr_q <= '0;
				chk_s1    <= 1'b0;
				hit_q     <= 1'b0;
			end else if (cmd.scan) begin
				if (rd_addr_q < CNT_W'(SCAN_END)) begin
					chk_s1    <= 1'b1;
					rd_addr_q <= rd_addr_q + 1'b1;
				end else begin
					chk_s1 <= 1'b0;
				end
				if (chk_s1 && erased_s1) hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			action_q      <= in_action;
			byte_index_q  <= in_byte_index;
			write_value_q <= in_write_value;
		end
		data_s1 <= mem[rd_addr_q[ADDR_W-1:0]];
		vld_s1  <= slot_vld_q[rd_addr_q[ADDR_W-1:0]];
		idx_s1  <= rd_addr_q[ADDR_W-1:0];
		if (cmd.scan && chk_s1) begin
			if (erased_s1) free_q <= idx_s1;
			else rec_q <= data_s1;
		end
	end

	// record decision
	assign found      = hit_q && (free_q != '0) && ({1'b0, free_q} < CNT_W'(SCAN_LIMIT));
	assign can_append = hit_q && ({1'b0, free_q} < CNT_W'(WRITE_LIMIT));
	assign old_byte   = found ? rec_q[{byte_index_q, 3'b000} +: BYTE_W] : '0;
	assign base_rec   = found ? rec_q : '0;

	always_comb begin
		new_rec = base_rec;
		new_rec[{byte_index_q, 3'b000} +: BYTE_W] = write_value_q;
	end

	assign do_write = (action_q == ACT_SAVE) && (!found || (old_byte != write_value_q));
	assign wr_en    = cmd.commit && do_write;
	assign wr_addr  = can_append ? free_q : '0;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= new_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_vld_q <= '0;
		end else if (wr_en) begin
			if (can_append) begin
				slot_vld_q[free_q] <= 1'b1;
			end else begin
				// page erase: only slot 0 holds the new record
				slot_vld_q <= PAGE_DEPTH'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_read_byte    <= (action_q == ACT_READ) ? old_byte : '0;
			out_record_found <= found;
			out_slot_written <= do_write;
			out_page_erased  <= do_write && !can_append;
		end
	end

	ap_erase_implies_write: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.commit) |-> (!out_page_erased || out_slot_written))
		else $error("page erase reported without a programmed record");

	ap_read_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cmd.commit) && (out_read_byte != '0) |-> !out_slot_written)
		else $error("nonzero read byte together with a programmed record");

	ap_hit_single: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (hit_q || !found))
		else $error("record reported found without an erased slot");

endmodule
`default_nettype wire

/* sv/flash_journal_byte_store_core.sv */
// Flash journal byte store: emulated 4-byte EEPROM as an append log in a 256-slot page.
// The response waits longer the later the first erased slot lies, bounded by the scan window.
// Throughput: one request at a time; the next is accepted only after the previous one
// commits, and later while a response waits to be taken.
// Reset: asynchronous, clears FSM, response valid and all slot valid bits (erased page).
// Depends on fjbs_pkg, fjbs_req_if, fjbs_rsp_if, fjbs_ctrl, fjbs_dp.
`default_nettype none
module flash_journal_byte_store_core (
	input  wire logic clk,
	input  wire logic arst_n,
	fjbs_req_if.sink   req,
	fjbs_rsp_if.source rsp
);
	import fjbs_pkg::*;

	fjbs_cmd_t cmd;
	fjbs_sts_t sts;

	// Controller: idle accepts a request, scan runs one slot per cycle until
	// the first erased slot (or the scan window end), apply waits for the
	// response register to be free, then commits.
	fjbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath: page memory, scan pipeline, record merge, response register.
	// A page erase clears all slot valid bits in the same cycle slot 0 is written.
	fjbs_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_action        (req.action),
		.in_byte_index    (req.byte_index),
		.in_write_value   (req.write_value),
		.out_read_byte    (rsp.read_byte),
		.out_record_found (rsp.record_found),
		.out_slot_written (rsp.slot_written),
		.out_page_erased  (rsp.page_erased)
	);

endmodule
`default_nettype wire
